// ----- rtl/core/scalar_kalman_sample_filter_top_defines.svh -----
// Assertion macros shared by the scalar Kalman filter RTL.
// Included by skf_ctrl and skf_datapath; expects aclk and aresetn in scope.
`ifndef SCALAR_KALMAN_SAMPLE_FILTER_TOP_DEFINES_SVH
`define SCALAR_KALMAN_SAMPLE_FILTER_TOP_DEFINES_SVH
`ifndef SYNTH
`define SKF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("skf assertion failed");
`define SKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("skf assertion failed");
`else
`define SKF_ASSERT(lbl, prop)
`define SKF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/skf_pkg.sv -----
// Package for the scalar Kalman filter: widths, reset values, FSM and control types.
// No dependencies.
package skf_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int FRAC_BITS    = 16;
    localparam int REG_BITS     = 24;
    localparam int COV_BITS     = 32;
    localparam int S_BITS       = COV_BITS + 1;
    localparam int D_BITS       = S_BITS + 1;
    localparam int K_BITS       = FRAC_BITS + 1;
    localparam int DIV_STEPS    = K_BITS;
    localparam int CNT_BITS     = $clog2(DIV_STEPS);
    localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [K_BITS-1:0]      ONE_FX    = K_BITS'(1) << FRAC_BITS;
    localparam logic [REG_BITS-1:0]    Q_RESET   = REG_BITS'(((2 ** FRAC_BITS) + 5) / 10);
    localparam logic [REG_BITS-1:0]    R_RESET   = REG_BITS'(2 ** FRAC_BITS);
    localparam logic [COV_BITS-1:0]    P_RESET   = COV_BITS'(2 ** FRAC_BITS);
    localparam logic [SAMPLE_BITS-1:0] EST_RESET = SAMPLE_BITS'(2 ** (SAMPLE_BITS - 1));

    localparam logic [CFG_IDX_BITS-1:0] REG_IDX_Q = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IDX_R = CFG_IDX_BITS'(1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_in;   // capture sample word
        logic sum;       // form S and D, seed divider
        logic div_step;  // one quotient bit
        logic mul;       // gain and products
        logic finish;    // update state and output word
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } stat_t;

endpackage

// ----- rtl/core/scalar_kalman_sample_filter_top.sv -----
// Scalar Kalman filter for 12-bit converter samples. Each accepted input word
// yields one filtered word in the output register. The 17-step restoring
// divider that forms the gain one quotient bit per cycle takes up most of
// the processing of each word; a result still waiting on the output side
// holds the datapath in its last step. The next word is accepted once the
// previous one has left the datapath, while its result may still wait.
// The user must write Q and R through the cfg port only while the filter is
// idle; the block itself does not enforce this.
// Top level: joins skf_ctrl and skf_datapath; depends on skf_pkg.
module scalar_kalman_sample_filter_top
    import skf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [REG_BITS-1:0]     cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [TDATA_BITS-1:0]   s_tdata,   // [11:0] sample
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_BITS-1:0]   m_tdata    // [11:0] filtered
);

    cmd_t                   cmd;
    stat_t                  stat;
    logic [SAMPLE_BITS-1:0] filtered;

    skf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    skf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .filtered  (filtered),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign m_tdata = TDATA_BITS'(filtered);

endmodule

// ----- rtl/core/skf_ctrl.sv -----
// Sequencer for the scalar Kalman filter: accepts a word, steps the datapath.
// Depends on skf_pkg and scalar_kalman_sample_filter_top_defines.svh.
`include "scalar_kalman_sample_filter_top_defines.svh"
module skf_ctrl
    import skf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output slot can take the word
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `SKF_ASSERT_NEXT(a_div_hold, state_reg == ST_DIV && !stat.div_last, state_reg == ST_DIV)
    `SKF_ASSERT(a_out_free, cmd.finish |-> (!m_valid_reg || m_tready))
    `SKF_ASSERT_NEXT(a_accept_to_sum, s_tvalid && s_tready, state_reg == ST_SUM && !m_valid_reg || state_reg == ST_SUM)

endmodule

// ----- rtl/core/skf_datapath.sv -----
// Datapath for the scalar Kalman filter: noise registers, filter state,
// restoring divider for the gain, products and output word. Depends on skf_pkg.
`include "scalar_kalman_sample_filter_top_defines.svh"
module skf_datapath
    import skf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [REG_BITS-1:0]     cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]  sample,
    output logic [SAMPLE_BITS-1:0]  filtered,
    input  cmd_t                    cmd,
    output stat_t                   stat
);

    localparam int PA_BITS = K_BITS + SAMPLE_BITS;
    localparam int PP_BITS = S_BITS + K_BITS;

    logic [REG_BITS-1:0]    q_reg, r_reg;
    logic [COV_BITS-1:0]    cov_reg;
    logic [SAMPLE_BITS-1:0] est_reg, x_reg, out_reg;
    logic [S_BITS-1:0]      s_reg;
    logic [D_BITS-1:0]      d_reg, rem_reg;
    logic [K_BITS-1:0]      quo_reg, k_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [PA_BITS-1:0]     pa_reg, pb_reg;
    logic [PP_BITS-1:0]     pp_reg;

    logic [S_BITS-1:0]      s_sum;
    logic [D_BITS:0]        rem_sh;
    logic                   rem_ge;
    logic [D_BITS-1:0]      rem_next;
    logic [K_BITS-1:0]      k_eff, wk;
    logic [PA_BITS:0]       acc;
    logic [PP_BITS-FRAC_BITS-1:0] p_full;
    logic [COV_BITS-1:0]    p_sat;

    assign s_sum = S_BITS'(cov_reg) + S_BITS'(q_reg);

    // first step compares S against D directly, later steps shift one bit in
    assign rem_sh   = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, d_reg};
    assign rem_next = rem_ge ? D_BITS'(rem_sh - {1'b0, d_reg}) : rem_sh[D_BITS-1:0];
    assign stat.div_last = (cnt_reg == CNT_BITS'(DIV_STEPS - 1));

    // zero denominator only when S and R are both zero: gain taken as zero
    assign k_eff = (d_reg == '0) ? '0 : quo_reg;
    assign wk    = ONE_FX - k_eff;

    assign acc    = {1'b0, pa_reg} + {1'b0, pb_reg};
    assign p_full = pp_reg[PP_BITS-1:FRAC_BITS];
    assign p_sat  = (|p_full[PP_BITS-FRAC_BITS-1:COV_BITS]) ? '1 : p_full[COV_BITS-1:0];

    assign filtered = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg   <= Q_RESET;
            r_reg   <= R_RESET;
            cov_reg <= P_RESET;
            est_reg <= EST_RESET;
        end else begin
            if (cfg_we && cfg_idx == REG_IDX_Q) begin
                q_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_idx == REG_IDX_R) begin
                r_reg <= cfg_wdata;
            end
            if (cmd.finish) begin
                cov_reg <= p_sat;
                est_reg <= acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg <= sample;
        end
        if (cmd.sum) begin
            s_reg   <= s_sum;
            d_reg   <= D_BITS'(s_sum) + D_BITS'(r_reg);
            rem_reg <= D_BITS'(s_sum);
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[K_BITS-2:0], rem_ge};
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
        if (cmd.mul) begin
            k_reg  <= k_eff;
            pa_reg <= PA_BITS'(wk) * PA_BITS'(est_reg);
            pb_reg <= PA_BITS'(k_eff) * PA_BITS'(x_reg);
            pp_reg <= PP_BITS'(s_reg) * PP_BITS'(wk);
        end
        if (cmd.finish) begin
            out_reg <= acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
        end
    end

    `SKF_ASSERT(a_gain_range, cmd.mul |-> (k_eff <= ONE_FX))
    `SKF_ASSERT_NEXT(a_full_gain, cmd.finish && k_reg == ONE_FX, cov_reg == '0 && est_reg == x_reg)
    `SKF_ASSERT_NEXT(a_zero_gain, cmd.finish && k_reg == '0, est_reg == $past(est_reg))

endmodule
